### hdl/cps_pkg.sv
// Shared types, constants and microcode for the cart-pole step engine.
// Used by cps_ctrl, cps_datapath and cart_pole_physics_step.
package cps_pkg;

    localparam int FRAC_BITS_DEF   = 24;
    localparam int CORDIC_ITER_DEF = 24;
    localparam int ATAN_ENTRIES    = 30;

    // CORDIC works in signed Q3.30
    localparam logic signed [33:0] TWO_PI_Q30  = 34'sd6746518852;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    // configuration register indexes
    localparam logic [1:0] REG_FORCE       = 2'd0;
    localparam logic [1:0] REG_POS_LIMIT   = 2'd1;
    localparam logic [1:0] REG_ANGLE_LIMIT = 2'd2;
    localparam logic [1:0] REG_STEP_LIMIT  = 2'd3;

    typedef enum logic [2:0] {
        OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_SINCOS, OP_COUNT, OP_CLEAR
    } op_t;

    typedef enum logic [4:0] {
        SRC_P, SRC_V, SRC_A, SRC_W, SRC_SN, SRC_CS, SRC_T1, SRC_T2, SRC_TEMP, SRC_NUM,
        SRC_TH, SRC_FORCE, SRC_C005, SRC_C11, SRC_C98, SRC_C01, SRC_C05, SRC_C43, SRC_C002
    } src_t;

    typedef struct packed {
        op_t  op;
        src_t a;
        src_t b;
        src_t dst;
        logic last;
    } uop_t;

    typedef struct packed {
        logic start;
        op_t  op;
        src_t a;
        src_t b;
        src_t dst;
        logic push;
        logic load;
        logic restart;
    } cmd_t;

    typedef struct packed {
        logic done;
    } stat_t;

    typedef struct packed {
        logic        truncated;
        logic        terminated;
        logic        reward;
        logic [31:0] pole_rate;
        logic [31:0] pole_angle;
        logic [31:0] cart_velocity;
        logic [31:0] cart_position;
    } obs_t;

    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_STEP    = 5'd0;
    localparam logic [PC_W-1:0] PC_RESTART = 5'd28;

    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        unique case (pc)
            5'd0:  return '{OP_SINCOS, SRC_A,     SRC_A,    SRC_SN,   1'b0};
            5'd1:  return '{OP_MUL,    SRC_C005,  SRC_W,    SRC_T1,   1'b0};
            5'd2:  return '{OP_MUL,    SRC_T1,    SRC_W,    SRC_T1,   1'b0};
            5'd3:  return '{OP_MUL,    SRC_T1,    SRC_SN,   SRC_T1,   1'b0};
            5'd4:  return '{OP_ADD,    SRC_FORCE, SRC_T1,   SRC_NUM,  1'b0};
            5'd5:  return '{OP_DIV,    SRC_NUM,   SRC_C11,  SRC_TEMP, 1'b0};
            5'd6:  return '{OP_MUL,    SRC_C98,   SRC_SN,   SRC_T1,   1'b0};
            5'd7:  return '{OP_MUL,    SRC_CS,    SRC_TEMP, SRC_T2,   1'b0};
            5'd8:  return '{OP_SUB,    SRC_T1,    SRC_T2,   SRC_NUM,  1'b0};
            5'd9:  return '{OP_MUL,    SRC_C01,   SRC_CS,   SRC_T1,   1'b0};
            5'd10: return '{OP_MUL,    SRC_T1,    SRC_CS,   SRC_T1,   1'b0};
            5'd11: return '{OP_DIV,    SRC_T1,    SRC_C11,  SRC_T1,   1'b0};
            5'd12: return '{OP_SUB,    SRC_C43,   SRC_T1,   SRC_T1,   1'b0};
            5'd13: return '{OP_MUL,    SRC_C05,   SRC_T1,   SRC_T2,   1'b0};
            5'd14: return '{OP_DIV,    SRC_NUM,   SRC_T2,   SRC_TH,   1'b0};
            5'd15: return '{OP_MUL,    SRC_C005,  SRC_TH,   SRC_T1,   1'b0};
            5'd16: return '{OP_MUL,    SRC_T1,    SRC_CS,   SRC_T1,   1'b0};
            5'd17: return '{OP_DIV,    SRC_T1,    SRC_C11,  SRC_T1,   1'b0};
            5'd18: return '{OP_SUB,    SRC_TEMP,  SRC_T1,   SRC_T2,   1'b0};
            5'd19: return '{OP_MUL,    SRC_C002,  SRC_V,    SRC_T1,   1'b0};
            5'd20: return '{OP_ADD,    SRC_P,     SRC_T1,   SRC_P,    1'b0};
            5'd21: return '{OP_MUL,    SRC_C002,  SRC_T2,   SRC_T1,   1'b0};
            5'd22: return '{OP_ADD,    SRC_V,     SRC_T1,   SRC_V,    1'b0};
            5'd23: return '{OP_MUL,    SRC_C002,  SRC_W,    SRC_T1,   1'b0};
            5'd24: return '{OP_ADD,    SRC_A,     SRC_T1,   SRC_A,    1'b0};
            5'd25: return '{OP_MUL,    SRC_C002,  SRC_TH,   SRC_T1,   1'b0};
            5'd26: return '{OP_ADD,    SRC_W,     SRC_T1,   SRC_W,    1'b0};
            5'd27: return '{OP_COUNT,  SRC_T1,    SRC_T1,   SRC_T1,   1'b1};
            default: return '{OP_CLEAR, SRC_T1,   SRC_T1,   SRC_T1,   1'b1};
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -66'sh0_8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage

### hdl/cps_datapath.sv
// Datapath of the cart-pole step engine: state registers, shared multiplier,
// bit-serial divider, iterative CORDIC and the result register. Uses cps_pkg.
module cps_datapath #(
    parameter int FRAC_BITS         = cps_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_ITERATIONS = cps_pkg::CORDIC_ITER_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cps_pkg::cmd_t cmd,
    output cps_pkg::stat_t stat,
    input  logic [30:0]   cfg_force,
    input  logic [30:0]   cfg_pos_limit,
    input  logic [30:0]   cfg_angle_limit,
    input  logic [15:0]   cfg_step_limit,
    output cps_pkg::obs_t obs
);
    import cps_pkg::*;

    localparam int ZS      = 30 - FRAC_BITS;
    localparam int ZW      = 63 - FRAC_BITS;
    localparam int DW      = 32 + FRAC_BITS;
    localparam int RED_TOP = 29 - FRAC_BITS;
    localparam int CW      = 6;

    localparam logic signed [31:0] C_005 = 32'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic signed [31:0] C_11  = 32'(((64'd11 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic signed [31:0] C_98  = 32'(((64'd98 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic signed [31:0] C_01  = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic signed [31:0] C_05  = 32'(((64'd1 << FRAC_BITS) + 64'd1) / 64'd2);
    localparam logic signed [31:0] C_43  = 32'(((64'd4 << FRAC_BITS) + 64'd1) / 64'd3);
    localparam logic signed [31:0] C_002 = 32'(((64'd2 << FRAC_BITS) + 64'd50) / 64'd100);

    localparam logic signed [65:0] MUL_RND = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [33:0] OUT_RND = 34'sd1 <<< (29 - FRAC_BITS);
    localparam logic [ZW-1:0]      TWO_PI_Z = ZW'(TWO_PI_Q30);

    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_MUL  = 7'b0000010,
        PH_DIV  = 7'b0000100,
        PH_RED  = 7'b0001000,
        PH_FOLD = 7'b0010000,
        PH_ROT  = 7'b0100000,
        PH_RND  = 7'b1000000
    } phase_t;

    phase_t phase_reg;
    logic   done_reg;
    logic [CW-1:0] cnt_reg;
    src_t   dst_reg;

    logic signed [31:0] p_reg, v_reg, a_reg, w_reg;
    logic signed [31:0] sn_reg, cs_reg, t1_reg, t2_reg, temp_reg, num_reg, th_reg;
    logic [15:0] steps_reg;

    logic signed [63:0] prod_reg;
    logic [31:0] rem_reg, qdl_reg, ub_reg;
    logic        neg_reg, ovf_reg;

    logic [ZW-1:0] zmag_reg;
    logic          zneg_reg, flip_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;

    obs_t obs_reg;

    logic signed [31:0] opa, opb, force_val, mul_res, div_res, wb_val;
    logic [31:0] ua, ub;
    logic [DW-1:0] dvd;
    logic [32:0] r2;
    logic        r_ge;
    logic        wb_en;
    src_t        wb_dst;
    logic signed [33:0] zr, zf, xs, ys, at, xf;
    logic        fold_flip;
    logic        trunc, out_of_bounds;
    logic signed [32:0] pl33, al33, p33, a33;

    function automatic logic signed [31:0] pick(
        input src_t s, input logic signed [31:0] p, input logic signed [31:0] v,
        input logic signed [31:0] a, input logic signed [31:0] w,
        input logic signed [31:0] sn, input logic signed [31:0] cs,
        input logic signed [31:0] t1, input logic signed [31:0] t2,
        input logic signed [31:0] tmp, input logic signed [31:0] num,
        input logic signed [31:0] th, input logic signed [31:0] frc);
        unique case (s)
            SRC_P:     return p;
            SRC_V:     return v;
            SRC_A:     return a;
            SRC_W:     return w;
            SRC_SN:    return sn;
            SRC_CS:    return cs;
            SRC_T1:    return t1;
            SRC_T2:    return t2;
            SRC_TEMP:  return tmp;
            SRC_NUM:   return num;
            SRC_TH:    return th;
            SRC_FORCE: return frc;
            SRC_C005:  return C_005;
            SRC_C11:   return C_11;
            SRC_C98:   return C_98;
            SRC_C01:   return C_01;
            SRC_C05:   return C_05;
            SRC_C43:   return C_43;
            SRC_C002:  return C_002;
            default:   return t1;
        endcase
    endfunction

    always_comb begin
        force_val = cmd.push ? $signed({1'b0, cfg_force}) : -$signed({1'b0, cfg_force});
        opa = pick(cmd.a, p_reg, v_reg, a_reg, w_reg, sn_reg, cs_reg, t1_reg, t2_reg,
                   temp_reg, num_reg, th_reg, force_val);
        opb = pick(cmd.b, p_reg, v_reg, a_reg, w_reg, sn_reg, cs_reg, t1_reg, t2_reg,
                   temp_reg, num_reg, th_reg, force_val);
        ua  = opa[31] ? 32'(-opa) : 32'(opa);
        ub  = opb[31] ? 32'(-opb) : 32'(opb);
        dvd = {ua, {FRAC_BITS{1'b0}}} + DW'(ub >> 1);

        mul_res = sat32((66'(prod_reg) + MUL_RND) >>> FRAC_BITS);

        r2   = {rem_reg, qdl_reg[31]};
        r_ge = r2 >= {1'b0, ub_reg};
        if (ovf_reg || qdl_reg[31]) begin
            div_res = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            div_res = neg_reg ? -$signed(qdl_reg) : $signed(qdl_reg);
        end

        // bring the reduced angle into [-pi, pi], then fold into [-pi/2, pi/2]
        zr = zneg_reg ? -$signed(34'(zmag_reg)) : $signed(34'(zmag_reg));
        zf = zr;
        fold_flip = 1'b0;
        if (zf > PI_Q30) zf = zf - TWO_PI_Q30;
        if (zf < -PI_Q30) zf = zf + TWO_PI_Q30;
        if (zf > HALF_PI_Q30) begin
            zf = PI_Q30 - zf;
            fold_flip = 1'b1;
        end else if (zf < -HALF_PI_Q30) begin
            zf = -PI_Q30 - zf;
            fold_flip = 1'b1;
        end

        xs = x_reg >>> cnt_reg[4:0];
        ys = y_reg >>> cnt_reg[4:0];
        at = $signed(34'(ATAN_Q30[cnt_reg[4:0]]));
        xf = flip_reg ? -x_reg : x_reg;

        wb_en  = 1'b0;
        wb_dst = dst_reg;
        wb_val = mul_res;
        case (phase_reg)
            PH_IDLE: begin
                if (cmd.start && cmd.op == OP_ADD) begin
                    wb_en  = 1'b1;
                    wb_dst = cmd.dst;
                    wb_val = sat32(66'(opa) + 66'(opb));
                end else if (cmd.start && cmd.op == OP_SUB) begin
                    wb_en  = 1'b1;
                    wb_dst = cmd.dst;
                    wb_val = sat32(66'(opa) - 66'(opb));
                end
            end
            PH_MUL: wb_en = 1'b1;
            PH_DIV: begin
                wb_en  = (cnt_reg == '0);
                wb_val = div_res;
            end
            default: ;
        endcase

        trunc = steps_reg >= cfg_step_limit;
        pl33  = $signed({2'b00, cfg_pos_limit});
        al33  = $signed({2'b00, cfg_angle_limit});
        p33   = 33'(p_reg);
        a33   = 33'(a_reg);
        out_of_bounds = (p33 > pl33) || (p33 < -pl33) || (a33 > al33) || (a33 < -al33);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            p_reg     <= '0;
            v_reg     <= '0;
            a_reg     <= '0;
            w_reg     <= '0;
            steps_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (wb_en) begin
                case (wb_dst)
                    SRC_P:    p_reg    <= wb_val;
                    SRC_V:    v_reg    <= wb_val;
                    SRC_A:    a_reg    <= wb_val;
                    SRC_W:    w_reg    <= wb_val;
                    SRC_T2:   t2_reg   <= wb_val;
                    SRC_TEMP: temp_reg <= wb_val;
                    SRC_NUM:  num_reg  <= wb_val;
                    SRC_TH:   th_reg   <= wb_val;
                    default:  t1_reg   <= wb_val;
                endcase
            end
            unique case (phase_reg)
                PH_IDLE: begin
                    if (cmd.start) begin
                        dst_reg <= cmd.dst;
                        unique case (cmd.op)
                            OP_MUL: begin
                                prod_reg  <= opa * opb;
                                phase_reg <= PH_MUL;
                            end
                            OP_DIV: begin
                                ub_reg    <= ub;
                                neg_reg   <= opa[31] != opb[31];
                                rem_reg   <= 32'(dvd[DW-1:32]);
                                ovf_reg   <= 32'(dvd[DW-1:32]) >= ub;
                                qdl_reg   <= dvd[31:0];
                                cnt_reg   <= CW'(32);
                                phase_reg <= PH_DIV;
                            end
                            OP_SINCOS: begin
                                zmag_reg  <= ZW'(ua) << ZS;
                                zneg_reg  <= opa[31];
                                cnt_reg   <= CW'(RED_TOP);
                                phase_reg <= PH_RED;
                            end
                            OP_COUNT: begin
                                if (steps_reg != 16'hFFFF) steps_reg <= steps_reg + 16'd1;
                                done_reg <= 1'b1;
                            end
                            OP_CLEAR: begin
                                p_reg     <= '0;
                                v_reg     <= '0;
                                a_reg     <= '0;
                                w_reg     <= '0;
                                steps_reg <= '0;
                                done_reg  <= 1'b1;
                            end
                            default: done_reg <= 1'b1;
                        endcase
                    end
                end
                PH_MUL: begin
                    done_reg  <= 1'b1;
                    phase_reg <= PH_IDLE;
                end
                PH_DIV: begin
                    if (cnt_reg == '0) begin
                        done_reg  <= 1'b1;
                        phase_reg <= PH_IDLE;
                    end else begin
                        rem_reg <= r_ge ? 32'(r2 - {1'b0, ub_reg}) : r2[31:0];
                        qdl_reg <= {qdl_reg[30:0], r_ge};
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                PH_RED: begin
                    if (zmag_reg >= (TWO_PI_Z << cnt_reg)) begin
                        zmag_reg <= zmag_reg - (TWO_PI_Z << cnt_reg);
                    end
                    if (cnt_reg == '0) phase_reg <= PH_FOLD;
                    else cnt_reg <= cnt_reg - 1'b1;
                end
                PH_FOLD: begin
                    z_reg     <= zf;
                    flip_reg  <= fold_flip;
                    x_reg     <= GAIN_Q30;
                    y_reg     <= '0;
                    cnt_reg   <= '0;
                    phase_reg <= PH_ROT;
                end
                PH_ROT: begin
                    if (!z_reg[33]) begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - at;
                    end else begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + at;
                    end
                    if (cnt_reg == CW'(CORDIC_ITERATIONS - 1)) phase_reg <= PH_RND;
                    else cnt_reg <= cnt_reg + 1'b1;
                end
                PH_RND: begin
                    cs_reg    <= sat32(66'((xf + OUT_RND) >>> ZS));
                    sn_reg    <= sat32(66'((y_reg + OUT_RND) >>> ZS));
                    done_reg  <= 1'b1;
                    phase_reg <= PH_IDLE;
                end
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    // result register: holds the item until the next load
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            if (cmd.restart) begin
                obs_reg <= '0;
            end else begin
                obs_reg.cart_position <= p_reg;
                obs_reg.cart_velocity <= v_reg;
                obs_reg.pole_angle    <= a_reg;
                obs_reg.pole_rate     <= w_reg;
                obs_reg.truncated     <= trunc;
                obs_reg.terminated    <= trunc || out_of_bounds;
                obs_reg.reward        <= !(trunc || out_of_bounds);
            end
        end
    end

    assign obs       = obs_reg;
    assign stat.done = done_reg;

`ifndef SYNTHESIS
    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg)) else $error("datapath phase not one-hot");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> phase_reg == PH_IDLE) else $error("op started while unit busy");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("done held for two cycles");
`endif

endmodule

### hdl/cps_ctrl.sv
// Sequencer of the cart-pole step engine: accepts items, steps through the
// microcode and hands results to the output channel. Uses cps_pkg.
module cps_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           s_restart,
    input  logic           s_push,
    output logic           m_tvalid,
    input  logic           m_tready,
    output cps_pkg::cmd_t  cmd,
    input  cps_pkg::stat_t stat
);
    import cps_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t          state_reg;
    logic [PC_W-1:0] pc_reg;
    logic            restart_reg, push_reg, m_valid_reg;
    uop_t            uop;
    logic            accept, load;

    assign uop      = ucode(pc_reg);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load     = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        cmd.start   = (state_reg == ST_ISSUE);
        cmd.op      = uop.op;
        cmd.a       = uop.a;
        cmd.b       = uop.b;
        cmd.dst     = uop.dst;
        cmd.push    = push_reg;
        cmd.load    = load;
        cmd.restart = restart_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= PC_STEP;
            restart_reg <= 1'b0;
            push_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        restart_reg <= s_restart;
                        push_reg    <= s_push;
                        pc_reg      <= s_restart ? PC_RESTART : PC_STEP;
                        state_reg   <= ST_ISSUE;
                    end
                end
                ST_ISSUE: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (stat.done) begin
                        if (uop.last) begin
                            state_reg <= ST_OUT;
                        end else begin
                            pc_reg    <= pc_reg + 1'b1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_OUT: begin
                    // hold until the previous item has left the result register
                    if (load) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> state_reg == ST_WAIT) else $error("done seen outside wait");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!m_valid_reg || m_tready)) else $error("result overwritten");
    a_accept_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_ISSUE && !m_valid_reg || state_reg == ST_ISSUE)
        else $error("accepted item not issued");
`endif

endmodule

### hdl/cart_pole_physics_step.sv
// Top level of the cart-pole Euler step engine: configuration registers and
// the stream ports around cps_ctrl and cps_datapath. Uses cps_pkg.
//
//  channel  ports                 payload
//  s_       tvalid/tready/tdata   tdata[0] push_right, tuser cmd
//  m_       tvalid/tready/tdata   observation, reward and flags
//  cfg_     wr_en/index/wr_data   force, position, angle and step limits
//
// A step item runs 14 multiplies, four divides (32 bit-serial iterations),
// sine and cosine (reduction, fold, 24 rotations) and 9 other ops, then it
// loads the result. Reset clears the state, the counter and the output valid.
// A new item is taken while a result waits on m_; its own result waits until
// that one leaves.
module cart_pole_physics_step #(
    parameter int FRAC_BITS         = cps_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_ITERATIONS = cps_pkg::CORDIC_ITER_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [0] push_right, [7:1] zero
    input  logic         s_tuser,     // [0] cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,     // [31:0] cart_position, [63:32] cart_velocity,
                                      // [95:64] pole_angle, [127:96] pole_rate,
                                      // [128] reward, [129] terminated,
                                      // [130] truncated, [135:131] zero
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_wr_data
);
    import cps_pkg::*;

    localparam logic [30:0] FORCE_RST = 31'((64'd10 << FRAC_BITS));
    localparam logic [30:0] POS_RST   = 31'(((64'd24 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [30:0] ANG_RST   = 31'(((64'd209 << FRAC_BITS) + 64'd500) / 64'd1000);

    logic [30:0] force_reg, pos_limit_reg, angle_limit_reg;
    logic [15:0] step_limit_reg;
    cmd_t        cmd;
    stat_t       stat;
    obs_t        obs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            force_reg       <= FORCE_RST;
            pos_limit_reg   <= POS_RST;
            angle_limit_reg <= ANG_RST;
            step_limit_reg  <= 16'd200;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FORCE:       force_reg       <= cfg_wr_data;
                REG_POS_LIMIT:   pos_limit_reg   <= cfg_wr_data;
                REG_ANGLE_LIMIT: angle_limit_reg <= cfg_wr_data;
                REG_STEP_LIMIT:  step_limit_reg  <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    cps_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_restart (s_tuser),
        .s_push    (s_tdata[0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    cps_datapath #(
        .FRAC_BITS         (FRAC_BITS),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_force       (force_reg),
        .cfg_pos_limit   (pos_limit_reg),
        .cfg_angle_limit (angle_limit_reg),
        .cfg_step_limit  (step_limit_reg),
        .obs             (obs)
    );

    assign m_tdata = {5'b00000, obs};

endmodule

### tb/tb_cart_pole_physics_step.sv
// Self-checking testbench for cart_pole_physics_step: drives step and restart items,
// predicts each observation in fixed point, and compares results field by field.
// Depends on cps_pkg for the register indexes and the observation layout.
module tb_cart_pole_physics_step;
    import cps_pkg::*;

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam int RANDOM_ITEMS = 1850;
    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;      // [0] push_right, [7:1] zero
    logic         s_tuser;      // [0] cmd
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;      // [127:0] position, velocity, angle, rate; [130:128] flags
    logic         cfg_wr_en;
    logic [1:0]   cfg_index;
    logic [30:0]  cfg_wr_data;

    cart_pole_physics_step DUT (.*);

    // predictor state and register copies
    longint force_mag, pos_lim, ang_lim, step_lim;
    longint cart_pos, cart_vel, pole_ang, pole_rt;
    int     step_cnt;

    obs_t   pending_obs[$];
    int     errors;
    int     items_sent;
    int     results_seen;
    bit     no_idle;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

    function automatic longint sat_q(longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    function automatic longint q_const(longint n, longint d);
        return ((n <<< 24) + d / 2) / d;
    endfunction

    function automatic longint q_mul(longint a, longint b);
        return sat_q((a * b + (64'sd1 <<< 23)) >>> 24);
    endfunction

    function automatic longint q_div(longint a, longint b);
        bit     neg;
        longint ua, ub, q;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        if (ub == 0) return (a >= 0) ? QMAX : QMIN;
        q = ((ua <<< 24) + ub / 2) / ub;
        if (q > 64'sh1_0000_0000) q = 64'sh1_0000_0000;
        return sat_q(neg ? -q : q);
    endfunction

    task automatic pole_sin_cos(input longint th, output longint sn, output longint cs);
        longint z, x, y, nx, atn;
        bit     flip;
        z = th * 64;
        x = longint'(GAIN_Q30);
        y = 0;
        flip = 1'b0;
        z = z % longint'(TWO_PI_Q30);
        if (z > longint'(PI_Q30)) z = z - longint'(TWO_PI_Q30);
        if (z < -longint'(PI_Q30)) z = z + longint'(TWO_PI_Q30);
        if (z > longint'(HALF_PI_Q30)) begin
            z = longint'(PI_Q30) - z;
            flip = 1'b1;
        end else if (z < -longint'(HALF_PI_Q30)) begin
            z = -longint'(PI_Q30) - z;
            flip = 1'b1;
        end
        for (int i = 0; i < 24; i++) begin
            atn = longint'({32'd0, ATAN_Q30[i]});
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atn;
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atn;
            end
            x = nx;
        end
        if (flip) x = -x;
        cs = sat_q((x + 32) >>> 6);
        sn = sat_q((y + 32) >>> 6);
    endtask

    // advance the cart-pole state by one item and return the observation
    task automatic advance_cart_pole(input logic cmd, input logic push, output obs_t obs);
        longint sn, cs, frc, temp, num, den, th_acc, x_acc, d;
        bit     done, trunc;
        obs = '0;
        if (cmd == CMD_RESTART) begin
            cart_pos = 0; cart_vel = 0; pole_ang = 0; pole_rt = 0;
            step_cnt = 0;
            return;
        end
        frc = push ? force_mag : -force_mag;
        pole_sin_cos(pole_ang, sn, cs);
        num = sat_q(frc + q_mul(q_mul(q_mul(q_const(5, 100), pole_rt), pole_rt), sn));
        temp = q_div(num, q_const(11, 10));
        num = sat_q(q_mul(q_const(98, 10), sn) - q_mul(cs, temp));
        d = q_div(q_mul(q_mul(q_const(1, 10), cs), cs), q_const(11, 10));
        den = q_mul(q_const(1, 2), sat_q(q_const(4, 3) - d));
        th_acc = q_div(num, den);
        x_acc = sat_q(temp - q_div(q_mul(q_mul(q_const(5, 100), th_acc), cs),
                                   q_const(11, 10)));
        cart_pos = sat_q(cart_pos + q_mul(q_const(2, 100), cart_vel));
        cart_vel = sat_q(cart_vel + q_mul(q_const(2, 100), x_acc));
        pole_ang = sat_q(pole_ang + q_mul(q_const(2, 100), pole_rt));
        pole_rt = sat_q(pole_rt + q_mul(q_const(2, 100), th_acc));
        if (step_cnt < 65535) step_cnt++;
        trunc = longint'(step_cnt) >= step_lim;
        done = cart_pos < -pos_lim || cart_pos > pos_lim ||
               pole_ang < -ang_lim || pole_ang > ang_lim || trunc;
        obs.cart_position = cart_pos[31:0];
        obs.cart_velocity = cart_vel[31:0];
        obs.pole_angle = pole_ang[31:0];
        obs.pole_rate = pole_rt[31:0];
        obs.reward = !done;
        obs.terminated = done;
        obs.truncated = trunc;
    endtask

    task automatic send_item(input logic cmd, input logic push);
        int   gap;
        obs_t obs;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {7'd0, push};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_cart_pole(cmd, push, obs);
        pending_obs.push_back(obs);
        items_sent++;
    endtask

    // drop valid and hold until every result has left the block
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_obs.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input longint value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value[30:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FORCE:       force_mag = value & 64'h7FFF_FFFF;
            REG_POS_LIMIT:   pos_lim = value & 64'h7FFF_FFFF;
            REG_ANGLE_LIMIT: ang_lim = value & 64'h7FFF_FFFF;
            REG_STEP_LIMIT:  step_lim = value & 64'hFFFF;
            default: ;
        endcase
    endtask

    task automatic configure(input longint frc, input longint pl, input longint al,
                             input longint sl);
        drain_results();
        write_reg(REG_FORCE, frc);
        write_reg(REG_POS_LIMIT, pl);
        write_reg(REG_ANGLE_LIMIT, al);
        write_reg(REG_STEP_LIMIT, sl);
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // result side: stall a random number of cycles per item unless no_idle is set
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            int stall;
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            obs_t want, got;
            got = m_tdata[$bits(obs_t)-1:0];
            results_seen++;
            if (pending_obs.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_obs.pop_front();
                report_field("cart_position", want.cart_position, got.cart_position);
                report_field("cart_velocity", want.cart_velocity, got.cart_velocity);
                report_field("pole_angle", want.pole_angle, got.pole_angle);
                report_field("pole_rate", want.pole_rate, got.pole_rate);
                report_field("reward", 32'(want.reward), 32'(got.reward));
                report_field("terminated", 32'(want.terminated), 32'(got.terminated));
                report_field("truncated", 32'(want.truncated), 32'(got.truncated));
            end
        end
    end

    task automatic test_reset_defaults();
        // steps straight out of reset run on the default registers
        send_item(CMD_STEP, 1'b1);
        send_item(CMD_STEP, 1'b0);
        send_item(CMD_STEP, 1'b1);
        send_item(CMD_RESTART, 1'b1);
        send_item(CMD_STEP, 1'b0);
    endtask

    task automatic test_step_limits();
        configure(q_const(10, 1), q_const(24, 10), q_const(209, 1000), 0);
        send_item(CMD_STEP, 1'b1);
        send_item(CMD_RESTART, 1'b0);
        configure(q_const(10, 1), q_const(24, 10), q_const(209, 1000), 1);
        send_item(CMD_STEP, 1'b0);
        send_item(CMD_STEP, 1'b0);
        configure(q_const(10, 1), q_const(24, 10), q_const(209, 1000), 65535);
        send_item(CMD_RESTART, 1'b0);
        send_item(CMD_STEP, 1'b1);
    endtask

    task automatic test_force_extremes();
        configure(0, QMAX, QMAX, 65535);
        send_item(CMD_RESTART, 1'b0);
        send_item(CMD_STEP, 1'b1);
        send_item(CMD_STEP, 1'b0);
        configure(QMAX, QMAX, QMAX, 65535);
        send_item(CMD_RESTART, 1'b0);
        for (int i = 0; i < 4; i++) send_item(CMD_STEP, 1'b1);
        send_item(CMD_STEP, 1'b0);
    endtask

    task automatic test_zero_bounds();
        configure(q_const(10, 1), 0, 0, 200);
        send_item(CMD_RESTART, 1'b1);
        send_item(CMD_STEP, 1'b1);
        send_item(CMD_STEP, 1'b0);
        send_item(CMD_RESTART, 1'b0);
    endtask

    task automatic test_random_episodes();
        longint frc, pl, al, sl;
        int     count;
        count = 0;
        while (count < RANDOM_ITEMS) begin
            if (count % 150 == 0) begin
                case ($urandom_range(0, 3))
                    0: frc = q_const(10, 1);
                    1: frc = $urandom_range(0, 32'h7FFF_FFFF);
                    2: frc = $urandom_range(0, 32'h0400_0000);
                    default: frc = ($urandom_range(0, 1)) ? QMAX : 0;
                endcase
                pl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                                 : $urandom_range(0, 32'h0600_0000);
                al = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                                 : $urandom_range(0, 32'h0100_0000);
                case ($urandom_range(0, 3))
                    0: sl = $urandom_range(1, 20);
                    1: sl = $urandom_range(0, 65535);
                    2: sl = 65535;
                    default: sl = 200;
                endcase
                no_idle = ($urandom_range(0, 3) == 0);
                configure(frc, pl, al, sl);
                send_item(CMD_RESTART, $urandom_range(0, 1));
                count++;
            end
            // mostly long episodes of steps, now and then a restart
            send_item(($urandom_range(0, 24) == 0) ? CMD_RESTART : CMD_STEP,
                      $urandom_range(0, 1));
            count++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        no_idle = 1'b0;
        force_mag = q_const(10, 1);
        pos_lim = q_const(24, 10);
        ang_lim = q_const(209, 1000);
        step_lim = 200;
        cart_pos = 0; cart_vel = 0; pole_ang = 0; pole_rt = 0;
        step_cnt = 0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wr_data <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_step_limits();
        test_force_extremes();
        test_zero_bounds();
        test_random_episodes();
        drain_results();

        $display("Ran %0d items (%0d results checked) over steps, restarts and", items_sent,
                 results_seen);
        $display("register settings from zero to full scale, with random stalls.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

### cart_pole_physics_step.f
hdl/cps_pkg.sv
hdl/cps_datapath.sv
hdl/cps_ctrl.sv
hdl/cart_pole_physics_step.sv
tb/tb_cart_pole_physics_step.sv
